### rtl/ccpt_pkg.sv
package ccpt_pkg;

  localparam int TOL_W = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd6554;
  localparam int RSQ_W = 64;

endpackage

### rtl/ccpt_div.sv
module ccpt_div #(
  parameter int NW = 50,
  parameter int DW = 33,
  parameter int QW = 32,
  parameter int PW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  input  logic [PW-1:0]        in_pay,
  output logic                 out_valid,
  output logic signed [QW-1:0] quo,
  output logic                 ovf,
  output logic [PW-1:0]        out_pay
);

  // Restoring division, one quotient bit per stage, then sign and saturation.
  localparam logic [NW-1:0] LIM = {{(NW-QW){1'b0}}, 1'b1, {(QW-1){1'b0}}};

  logic [NW-1:0] nq  [0:NW];
  logic [DW-1:0] rem [0:NW];
  logic [DW-1:0] dv  [0:NW];
  logic          neg [0:NW];
  logic          zz  [0:NW];
  logic          vld [0:NW];
  logic [PW-1:0] pay [0:NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      nq[0]  <= num[NW-1] ? -num : num;
      dv[0]  <= den[DW-1] ? -den : den;
      neg[0] <= num[NW-1] ^ den[DW-1];
      zz[0]  <= (num == '0) && (den == '0);
      rem[0] <= '0;
      pay[0] <= in_pay;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem[k], nq[k][NW-1]};
    assign diff  = trial - {1'b0, dv[k]};
    assign ge    = trial >= {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nq[k+1]  <= {nq[k][NW-2:0], ge};
        dv[k+1]  <= dv[k];
        neg[k+1] <= neg[k];
        zz[k+1]  <= zz[k];
        pay[k+1] <= pay[k];
      end
    end
  end

  logic [NW-1:0] qm;
  logic [NW-1:0] qn;
  assign qm = nq[NW];
  assign qn = -qm;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NW];
    end
    if (en) begin
      out_pay <= pay[NW];
      if (zz[NW]) begin
        quo <= '0;
        ovf <= 1'b1;
      end else if (neg[NW]) begin
        if (qm > LIM) begin
          quo <= {1'b1, {(QW-1){1'b0}}};
          ovf <= 1'b1;
        end else begin
          quo <= qn[QW-1:0];
          ovf <= 1'b0;
        end
      end else if (qm >= LIM) begin
        quo <= {1'b0, {(QW-1){1'b1}}};
        ovf <= 1'b1;
      end else begin
        quo <= qm[QW-1:0];
        ovf <= 1'b0;
      end
    end
  end

endmodule

### rtl/circumcircle_point_test.sv
// Channel     Direction  Handshake                 Payload
// s_axis      in         s_tvalid / s_tready       test point and vertices A, B, C
// m_axis      out        m_tvalid / m_tready       inside, degenerate, centre, r^2, overflow
// cfg         in         cfg_we                    tolerance
//
// One word is accepted per cycle while no result is waiting; each result passes in order
// through the input stages, the two bit-per-stage slope dividers, the bit-per-stage
// centre divider and the stages after it.
// Reset clears the valid bits and loads the tolerance with its default.
// A waiting result holds the whole pipeline; nothing is lost or repeated.
module circumcircle_point_test #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // test_x, test_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y
  input  logic [8*COORD_WIDTH-1:0]            s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // inside_res, degenerate, center_x, center_y, radius_sq, overflow, zero fill
  output logic [((2*COORD_WIDTH+ccpt_pkg::RSQ_W+3+7)/8)*8-1:0] m_tdata,
  input  logic                                cfg_we,
  input  logic [ccpt_pkg::TOL_W-1:0]          cfg_wdata
);

  import ccpt_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int C1    = CW + 1;
  localparam int SNW   = CW + FB + 2;
  localparam int NUMW  = ((2*CW+1 > CW+FB+1) ? 2*CW+1 : CW+FB+1) + 1;
  localparam int LW    = 2*CW + 2;
  localparam int SQW   = 2*CW + 1;
  localparam int R2W   = 2*CW + 2;
  localparam int R2X   = ((R2W > RSQ_W) ? R2W : RSQ_W) + 1;
  localparam int TW    = ((R2W > TOL_W+FB) ? R2W : TOL_W+FB) + 1;
  localparam int EW    = (C1 > TOL_W) ? C1 : TOL_W;
  localparam int OUT_W = ((2*CW+RSQ_W+3+7)/8)*8;
  localparam int P1W   = 3 + 4*CW;
  localparam int P2W   = 4*CW;
  localparam int P3W   = 4 + 9*CW;

  logic en;
  logic [TOL_W-1:0] tol;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_wdata;
    end
  end

  // Stage A: input register.
  logic a_v;
  logic signed [CW-1:0] a_tx, a_ty, a_ax, a_ay, a_bx, a_by, a_cx, a_cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= s_tvalid;
    end
    if (en) begin
      a_tx <= s_tdata[CW-1:0];
      a_ty <= s_tdata[2*CW-1:CW];
      a_ax <= s_tdata[3*CW-1:2*CW];
      a_ay <= s_tdata[4*CW-1:3*CW];
      a_bx <= s_tdata[5*CW-1:4*CW];
      a_by <= s_tdata[6*CW-1:5*CW];
      a_cx <= s_tdata[7*CW-1:6*CW];
      a_cy <= s_tdata[8*CW-1:7*CW];
    end
  end

  // Stage B: edge differences and midpoints.
  logic b_v;
  logic signed [C1-1:0] b_dx1, b_dy1, b_dx2, b_dy2;
  logic signed [CW-1:0] b_mx1, b_my1, b_mx2, b_my2, b_bx, b_by, b_tx, b_ty;
  logic [C1-1:0] s_mx1, s_my1, s_mx2, s_my2;

  assign s_mx1 = {a_ax[CW-1], a_ax} + {a_bx[CW-1], a_bx};
  assign s_my1 = {a_ay[CW-1], a_ay} + {a_by[CW-1], a_by};
  assign s_mx2 = {a_bx[CW-1], a_bx} + {a_cx[CW-1], a_cx};
  assign s_my2 = {a_by[CW-1], a_by} + {a_cy[CW-1], a_cy};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
    if (en) begin
      b_dx1 <= {a_bx[CW-1], a_bx} - {a_ax[CW-1], a_ax};
      b_dy1 <= {a_by[CW-1], a_by} - {a_ay[CW-1], a_ay};
      b_dx2 <= {a_cx[CW-1], a_cx} - {a_bx[CW-1], a_bx};
      b_dy2 <= {a_cy[CW-1], a_cy} - {a_by[CW-1], a_by};
      b_mx1 <= s_mx1[C1-1:1];
      b_my1 <= s_my1[C1-1:1];
      b_mx2 <= s_mx2[C1-1:1];
      b_my2 <= s_my2[C1-1:1];
      b_bx  <= a_bx;
      b_by  <= a_by;
      b_tx  <= a_tx;
      b_ty  <= a_ty;
    end
  end

  // Stage C: flat-edge flags and slope numerators.
  logic c_v, c_f1, c_f2, c_gt;
  logic signed [SNW-1:0] c_n1, c_n2;
  logic signed [C1-1:0]  c_dy1, c_dy2;
  logic signed [CW-1:0]  c_mx1, c_my1, c_mx2, c_my2, c_bx, c_by, c_tx, c_ty;
  logic [C1-1:0] a12, a23;
  logic [CW+1:0] nd1, nd2;

  assign a12 = b_dy1[CW] ? -b_dy1 : b_dy1;
  assign a23 = b_dy2[CW] ? -b_dy2 : b_dy2;
  assign nd1 = -{b_dx1[CW], b_dx1};
  assign nd2 = -{b_dx2[CW], b_dx2};

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
    if (en) begin
      c_f1  <= EW'(a12) < EW'(tol);
      c_f2  <= EW'(a23) < EW'(tol);
      c_gt  <= a12 > a23;
      c_n1  <= {nd1, {FB{1'b0}}};
      c_n2  <= {nd2, {FB{1'b0}}};
      c_dy1 <= b_dy1;
      c_dy2 <= b_dy2;
      c_mx1 <= b_mx1;
      c_my1 <= b_my1;
      c_mx2 <= b_mx2;
      c_my2 <= b_my2;
      c_bx  <= b_bx;
      c_by  <= b_by;
      c_tx  <= b_tx;
      c_ty  <= b_ty;
    end
  end

  // Bisector slopes.
  logic d1_v, d2_v, ov1, ov2;
  logic signed [CW-1:0] m1, m2;
  logic [P1W-1:0] pay1;
  logic [P2W-1:0] pay2;
  logic p_f1, p_f2, p_gt;
  logic signed [CW-1:0] p_mx1, p_my1, p_bx, p_tx, p_mx2, p_my2, p_by, p_ty;

  ccpt_div #(.NW(SNW), .DW(C1), .QW(CW), .PW(P1W)) u_slope_ab (
    .clk(clk), .rst(rst), .en(en), .in_valid(c_v), .num(c_n1), .den(c_dy1),
    .in_pay({c_f1, c_f2, c_gt, c_mx1, c_my1, c_bx, c_tx}),
    .out_valid(d1_v), .quo(m1), .ovf(ov1), .out_pay(pay1)
  );

  ccpt_div #(.NW(SNW), .DW(C1), .QW(CW), .PW(P2W)) u_slope_bc (
    .clk(clk), .rst(rst), .en(en), .in_valid(c_v), .num(c_n2), .den(c_dy2),
    .in_pay({c_mx2, c_my2, c_by, c_ty}),
    .out_valid(d2_v), .quo(m2), .ovf(ov2), .out_pay(pay2)
  );

  assign {p_f1, p_f2, p_gt, p_mx1, p_my1, p_bx, p_tx} = pay1;
  assign {p_mx2, p_my2, p_by, p_ty} = pay2;

  // Stage D: case selection and numerator products.
  logic d_v, d_deg, d_ovs, d_gen, d_f1;
  logic signed [2*CW-1:0] d_p1, d_p2;
  logic signed [C1-1:0]   d_dmy, d_dm;
  logic signed [CW-1:0]   d_mx1, d_mx2, d_msel, d_mxsel, d_mysel, d_bx, d_by, d_tx, d_ty;
  logic gen, sel;

  assign gen = !p_f1 && !p_f2;
  assign sel = gen ? p_gt : p_f2;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= d1_v && d2_v;
    end
    if (en) begin
      d_deg   <= (p_f1 && p_f2) || (gen && (m1 == m2));
      d_ovs   <= (!p_f1 && ov1) || (!p_f2 && ov2);
      d_gen   <= gen;
      d_f1    <= p_f1;
      d_p1    <= m1 * p_mx1;
      d_p2    <= m2 * p_mx2;
      d_dmy   <= {p_my2[CW-1], p_my2} - {p_my1[CW-1], p_my1};
      d_dm    <= {m1[CW-1], m1} - {m2[CW-1], m2};
      d_mx1   <= p_mx1;
      d_mx2   <= p_mx2;
      d_msel  <= sel ? m1 : m2;
      d_mxsel <= sel ? p_mx1 : p_mx2;
      d_mysel <= sel ? p_my1 : p_my2;
      d_bx    <= p_bx;
      d_by    <= p_by;
      d_tx    <= p_tx;
      d_ty    <= p_ty;
    end
  end

  // Stage E: centre numerator.
  logic e_v;
  logic signed [NUMW-1:0] e_num;
  logic signed [C1-1:0]   e_dm;
  logic [P3W-1:0]         e_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= d_v;
    end
    if (en) begin
      e_num <= NUMW'(d_p1) - NUMW'(d_p2) + (NUMW'(d_dmy) <<< FB);
      e_dm  <= d_dm;
      e_pay <= {d_deg, d_ovs, d_gen, d_f1, d_mx1, d_mx2, d_msel, d_mxsel, d_mysel,
                d_bx, d_by, d_tx, d_ty};
    end
  end

  logic q_v, q_ov;
  logic signed [CW-1:0] q_cx;
  logic [P3W-1:0] pay3;
  logic q_deg, q_ovs, q_gen, q_f1;
  logic signed [CW-1:0] q_mx1, q_mx2, q_msel, q_mxsel, q_mysel, q_bx, q_by, q_tx, q_ty;

  ccpt_div #(.NW(NUMW), .DW(C1), .QW(CW), .PW(P3W)) u_centre (
    .clk(clk), .rst(rst), .en(en), .in_valid(e_v), .num(e_num), .den(e_dm),
    .in_pay(e_pay), .out_valid(q_v), .quo(q_cx), .ovf(q_ov), .out_pay(pay3)
  );

  assign {q_deg, q_ovs, q_gen, q_f1, q_mx1, q_mx2, q_msel, q_mxsel, q_mysel,
          q_bx, q_by, q_tx, q_ty} = pay3;

  // Stage F: centre x.
  logic f_v, f_deg, f_ov;
  logic signed [CW-1:0] f_pcx, f_msel, f_mxsel, f_mysel, f_bx, f_by, f_tx, f_ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= q_v;
    end
    if (en) begin
      f_pcx   <= q_gen ? q_cx : (q_f1 ? q_mx1 : q_mx2);
      f_ov    <= q_ovs || (q_gen && q_ov);
      f_deg   <= q_deg;
      f_msel  <= q_msel;
      f_mxsel <= q_mxsel;
      f_mysel <= q_mysel;
      f_bx    <= q_bx;
      f_by    <= q_by;
      f_tx    <= q_tx;
      f_ty    <= q_ty;
    end
  end

  // Stage G: offsets from the centre x.
  logic g_v, g_deg, g_ov;
  logic signed [C1-1:0] g_ly, g_ebx, g_etx;
  logic signed [CW-1:0] g_msel, g_mysel, g_by, g_ty, g_pcx;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (en) begin
      g_v <= f_v;
    end
    if (en) begin
      g_ly    <= {f_pcx[CW-1], f_pcx} - {f_mxsel[CW-1], f_mxsel};
      g_ebx   <= {f_bx[CW-1], f_bx} - {f_pcx[CW-1], f_pcx};
      g_etx   <= {f_tx[CW-1], f_tx} - {f_pcx[CW-1], f_pcx};
      g_msel  <= f_msel;
      g_mysel <= f_mysel;
      g_by    <= f_by;
      g_ty    <= f_ty;
      g_pcx   <= f_pcx;
      g_deg   <= f_deg;
      g_ov    <= f_ov;
    end
  end

  // Stage H: bisector product and x squares.
  logic h_v, h_deg, h_ov;
  logic signed [2*CW:0]   h_lp;
  logic [SQW-1:0]         h_sbx, h_stx;
  logic signed [CW-1:0]   h_mysel, h_by, h_ty, h_pcx;
  logic signed [2*CW+1:0] sq_bx, sq_tx;

  assign sq_bx = g_ebx * g_ebx;
  assign sq_tx = g_etx * g_etx;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (en) begin
      h_v <= g_v;
    end
    if (en) begin
      h_lp    <= g_msel * g_ly;
      h_sbx   <= sq_bx[SQW-1:0];
      h_stx   <= sq_tx[SQW-1:0];
      h_mysel <= g_mysel;
      h_by    <= g_by;
      h_ty    <= g_ty;
      h_pcx   <= g_pcx;
      h_deg   <= g_deg;
      h_ov    <= g_ov;
    end
  end

  // Stage I: centre y with saturation.
  logic i_v, i_deg, i_ov;
  logic signed [CW-1:0] i_pcy, i_by, i_ty, i_pcx;
  logic [SQW-1:0] i_sbx, i_stx;
  logic signed [2*CW:0]   lsh;
  logic signed [LW-1:0]   lsum;
  logic [LW-CW:0]         lhi;
  logic                   yov;

  assign lsh  = h_lp >>> FB;
  assign lsum = LW'(lsh) + LW'(h_mysel);
  assign lhi  = lsum[LW-1:CW-1];
  assign yov  = !((&lhi) || !(|lhi));

  always_ff @(posedge clk) begin
    if (rst) begin
      i_v <= 1'b0;
    end else if (en) begin
      i_v <= h_v;
    end
    if (en) begin
      if (yov) begin
        i_pcy <= lsum[LW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        i_pcy <= lsum[CW-1:0];
      end
      i_ov  <= h_ov || yov;
      i_deg <= h_deg;
      i_by  <= h_by;
      i_ty  <= h_ty;
      i_pcx <= h_pcx;
      i_sbx <= h_sbx;
      i_stx <= h_stx;
    end
  end

  // Stage J: offsets from the centre y.
  logic j_v, j_deg, j_ov;
  logic signed [C1-1:0] j_eby, j_ety;
  logic signed [CW-1:0] j_pcx, j_pcy;
  logic [SQW-1:0] j_sbx, j_stx;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_v <= 1'b0;
    end else if (en) begin
      j_v <= i_v;
    end
    if (en) begin
      j_eby <= {i_by[CW-1], i_by} - {i_pcy[CW-1], i_pcy};
      j_ety <= {i_ty[CW-1], i_ty} - {i_pcy[CW-1], i_pcy};
      j_pcx <= i_pcx;
      j_pcy <= i_pcy;
      j_sbx <= i_sbx;
      j_stx <= i_stx;
      j_deg <= i_deg;
      j_ov  <= i_ov;
    end
  end

  // Stage K: y squares.
  logic k_v, k_deg, k_ov;
  logic [SQW-1:0] k_sbx, k_stx, k_sby, k_sty;
  logic signed [CW-1:0] k_pcx, k_pcy;
  logic signed [2*CW+1:0] sq_by, sq_ty;

  assign sq_by = j_eby * j_eby;
  assign sq_ty = j_ety * j_ety;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_v <= 1'b0;
    end else if (en) begin
      k_v <= j_v;
    end
    if (en) begin
      k_sby <= sq_by[SQW-1:0];
      k_sty <= sq_ty[SQW-1:0];
      k_sbx <= j_sbx;
      k_stx <= j_stx;
      k_pcx <= j_pcx;
      k_pcy <= j_pcy;
      k_deg <= j_deg;
      k_ov  <= j_ov;
    end
  end

  // Stage L: squared distances.
  logic l_v, l_deg, l_ov;
  logic [R2W-1:0] l_r2, l_t2;
  logic signed [CW-1:0] l_pcx, l_pcy;

  always_ff @(posedge clk) begin
    if (rst) begin
      l_v <= 1'b0;
    end else if (en) begin
      l_v <= k_v;
    end
    if (en) begin
      l_r2  <= R2W'(k_sbx) + R2W'(k_sby);
      l_t2  <= R2W'(k_stx) + R2W'(k_sty);
      l_pcx <= k_pcx;
      l_pcy <= k_pcy;
      l_deg <= k_deg;
      l_ov  <= k_ov;
    end
  end

  // Stage M: inside test and output register.
  logic o_inside, o_deg, o_ov;
  logic signed [CW-1:0] o_cx, o_cy;
  logic [RSQ_W-1:0] o_rsq;
  logic [TW-1:0]    thr;
  logic [R2X-1:0]   r2x;
  logic             rsat;

  assign thr  = TW'(l_r2) + (TW'(tol) << FB);
  assign r2x  = R2X'(l_r2);
  assign rsat = |r2x[R2X-1:RSQ_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= l_v;
    end
    if (en) begin
      o_deg <= l_deg;
      if (l_deg) begin
        o_inside <= 1'b0;
        o_cx     <= '0;
        o_cy     <= '0;
        o_rsq    <= '0;
        o_ov     <= 1'b0;
      end else begin
        o_inside <= TW'(l_t2) <= thr;
        o_cx     <= l_pcx;
        o_cy     <= l_pcy;
        o_rsq    <= rsat ? {RSQ_W{1'b1}} : r2x[RSQ_W-1:0];
        o_ov     <= l_ov || rsat;
      end
    end
  end

  assign m_tdata = {{(OUT_W-2*CW-RSQ_W-3){1'b0}}, o_ov, o_rsq, o_cy, o_cx, o_deg, o_inside};

  a_deg_clean : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_deg |-> !o_inside && !o_ov && (o_rsq == '0))
    else $error("Degenerate result carries inside, overflow or radius.");

  a_entry : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> a_v)
    else $error("Accepted word did not enter the pipeline.");

  a_reset : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result valid after reset.");

endmodule

### bench/circumcircle_point_test_tb.sv
`timescale 1ns / 100ps

module circumcircle_point_test_tb;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int OUT_W = ((2*CW+ccpt_pkg::RSQ_W+3+7)/8)*8;
  localparam longint MAXC = (64'sd1 <<< (CW-1)) - 1;
  localparam longint MINC = -MAXC - 1;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN = 150;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    bit hit;
    bit degen;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [63:0] rsq;
    bit ov;
  } circle_t;

  class circle_scoreboard;
    circle_t expected_circles[$];
    longint tol;
    int errors;
    int reported;

    function new();
      tol = ccpt_pkg::TOL_RESET;
      errors = 0;
      reported = 0;
    endfunction

    function automatic longint clamp_coord(wide_t a, inout bit ov);
      if (a > wide_t'(MAXC)) begin
        ov = 1;
        return MAXC;
      end
      if (a < wide_t'(MINC)) begin
        ov = 1;
        return MINC;
      end
      return longint'(a);
    endfunction

    function automatic longint quot_sat(wide_t n, longint d, inout bit ov);
      wide_t q;
      if (d == 0) begin
        ov = 1;
        if (n == 0) return 0;
        return (n < 0) ? MINC : MAXC;
      end
      q = n / wide_t'(d);
      return clamp_coord(q, ov);
    endfunction

    function automatic longint bisector_slope(longint dx, longint dy, inout bit ov);
      return quot_sat(wide_t'(-dx) <<< FB, dy, ov);
    endfunction

    function automatic longint bisector_y(longint m, longint px, longint mx, longint my,
                                          inout bit ov);
      wide_t p;
      p = (wide_t'(m) * wide_t'(px - mx)) >>> FB;
      return clamp_coord(p + wide_t'(my), ov);
    endfunction

    function automatic wide_t dist_sq(longint x0, longint y0, longint x1, longint y1);
      return wide_t'(x0 - x1) * wide_t'(x0 - x1) + wide_t'(y0 - y1) * wide_t'(y0 - y1);
    endfunction

    function automatic circle_t predict_circle(logic [8*CW-1:0] w);
      longint tx, ty, ax, ay, bx, by, qx, qy;
      longint d12, d23, a12, a23, m1, m2, mx1, mx2, my1, my2, px, py;
      bit f1, f2, ov, deg;
      wide_t num, r2, t2, t;
      circle_t r;
      tx = longint'($signed(w[0*CW +: CW]));
      ty = longint'($signed(w[1*CW +: CW]));
      ax = longint'($signed(w[2*CW +: CW]));
      ay = longint'($signed(w[3*CW +: CW]));
      bx = longint'($signed(w[4*CW +: CW]));
      by = longint'($signed(w[5*CW +: CW]));
      qx = longint'($signed(w[6*CW +: CW]));
      qy = longint'($signed(w[7*CW +: CW]));
      d12 = ay - by;
      d23 = by - qy;
      a12 = d12 < 0 ? -d12 : d12;
      a23 = d23 < 0 ? -d23 : d23;
      f1 = a12 < tol;
      f2 = a23 < tol;
      ov = 0;
      deg = 0;
      px = 0;
      py = 0;
      r = '{default: '0};
      if (f1 && f2) begin
        deg = 1;
      end else if (f1) begin
        m2 = bisector_slope(qx - bx, qy - by, ov);
        px = (bx + ax) >>> 1;
        py = bisector_y(m2, px, (bx + qx) >>> 1, (by + qy) >>> 1, ov);
      end else if (f2) begin
        m1 = bisector_slope(bx - ax, by - ay, ov);
        px = (qx + bx) >>> 1;
        py = bisector_y(m1, px, (ax + bx) >>> 1, (ay + by) >>> 1, ov);
      end else begin
        m1 = bisector_slope(bx - ax, by - ay, ov);
        m2 = bisector_slope(qx - bx, qy - by, ov);
        mx1 = (ax + bx) >>> 1;
        mx2 = (bx + qx) >>> 1;
        my1 = (ay + by) >>> 1;
        my2 = (by + qy) >>> 1;
        if (m1 == m2) begin
          deg = 1;
        end else begin
          num = wide_t'(m1) * wide_t'(mx1) - wide_t'(m2) * wide_t'(mx2)
                + (wide_t'(my2 - my1) <<< FB);
          px = quot_sat(num, m1 - m2, ov);
          if (a12 > a23) py = bisector_y(m1, px, mx1, my1, ov);
          else py = bisector_y(m2, px, mx2, my2, ov);
        end
      end
      if (deg) begin
        r.degen = 1;
      end else begin
        r2 = dist_sq(bx, by, px, py);
        t2 = dist_sq(tx, ty, px, py);
        t = t2 - r2 - (wide_t'(tol) <<< FB);
        r.hit = (t <= 0);
        if (r2[127:64] != 0) begin
          ov = 1;
          r.rsq = '1;
        end else begin
          r.rsq = r2[63:0];
        end
        r.cx = px[CW-1:0];
        r.cy = py[CW-1:0];
        r.ov = ov;
      end
      return r;
    endfunction

    function void note_word(logic [8*CW-1:0] w);
      expected_circles.push_back(predict_circle(w));
    endfunction

    function void check_word(logic [OUT_W-1:0] d);
      circle_t e, a;
      a.hit = d[0];
      a.degen = d[1];
      a.cx = d[2 +: CW];
      a.cy = d[2+CW +: CW];
      a.rsq = d[2+2*CW +: 64];
      a.ov = d[2+2*CW+64];
      if (expected_circles.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("Unexpected result word %h", d);
        end
        return;
      end
      e = expected_circles.pop_front();
      if (a.hit !== e.hit || a.degen !== e.degen || a.cx !== e.cx ||
          a.cy !== e.cy || a.rsq !== e.rsq || a.ov !== e.ov) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("Mismatch: expected inside=%0d degen=%0d cx=%h cy=%h rsq=%h ov=%0d",
                   e.hit, e.degen, e.cx, e.cy, e.rsq, e.ov);
          $display("          actual   inside=%0d degen=%0d cx=%h cy=%h rsq=%h ov=%0d",
                   a.hit, a.degen, a.cx, a.cy, a.rsq, a.ov);
        end
      end
    endfunction

    function int pending();
      return expected_circles.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [8*CW-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we;
  logic [ccpt_pkg::TOL_W-1:0] cfg_wdata;

  circle_scoreboard sb = new();
  bit calm;
  int stall;
  int idle_cycles;

  circumcircle_point_test u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [8*CW-1:0] pack_item(longint tx, longint ty, longint ax,
                                                longint ay, longint bx, longint by,
                                                longint qx, longint qy);
    return {qy[CW-1:0], qx[CW-1:0], by[CW-1:0], bx[CW-1:0],
            ay[CW-1:0], ax[CW-1:0], ty[CW-1:0], tx[CW-1:0]};
  endfunction

  function automatic longint rand_coord(int scale);
    return longint'(int'($urandom)) >>> (31 - scale);
  endfunction

  function automatic logic [8*CW-1:0] random_item();
    int scale, shape;
    longint tx, ty, ax, ay, bx, by, qx, qy, dx, dy;
    scale = $urandom_range(0, 9) < 5 ? 23 : ($urandom_range(0, 1) ? 28 : 31);
    shape = $urandom_range(0, 9);
    ax = rand_coord(scale);
    ay = rand_coord(scale);
    bx = rand_coord(scale);
    by = rand_coord(scale);
    qx = rand_coord(scale);
    qy = rand_coord(scale);
    case (shape)
      6: ay = by + (rand_coord(31) >>> $urandom_range(13, 31));
      7: qy = by + (rand_coord(31) >>> $urandom_range(13, 31));
      8: begin
        dx = rand_coord(18);
        dy = rand_coord(18);
        bx = ax + dx;
        by = ay + dy;
        qx = ax - 3 * dx;
        qy = ay - 3 * dy;
      end
      9: begin
        if ($urandom_range(0, 1)) begin
          bx = ax;
          by = ay;
        end else begin
          qx = bx;
          qy = by;
        end
      end
      default: ;
    endcase
    if ($urandom_range(0, 1)) begin
      tx = bx + rand_coord($urandom_range(4, 20));
      ty = by + rand_coord($urandom_range(4, 20));
    end else begin
      tx = rand_coord(scale);
      ty = rand_coord(scale);
    end
    return pack_item(tx, ty, ax, ay, bx, by, qx, qy);
  endfunction

  task automatic send_word(logic [8*CW-1:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    do @(posedge clk); while (!s_tready);
    sb.note_word(w);
  endtask

  task automatic write_tolerance(logic [ccpt_pkg::TOL_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.tol = v;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_directed();
    send_word(pack_item(0, 0, 0, 0, 0, 0, 0, 0));
    send_word(pack_item(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
    send_word(pack_item(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC));
    send_word(pack_item(MAXC, MINC, MINC, MAXC, MAXC, MINC, MINC, MINC));
    send_word(pack_item(MINC, MAXC, MAXC, MINC, MINC, MAXC, MAXC, MAXC));
    send_word(pack_item(0, 0, ONE, ONE, ONE, ONE, ONE, ONE));
    send_word(pack_item(0, 0, 0, 0, ONE, ONE, 2*ONE, 2*ONE));
    send_word(pack_item(ONE, ONE, 0, 0, 2*ONE, 0, ONE, 3*ONE));
    send_word(pack_item(ONE, ONE, ONE, 3*ONE, 0, 0, 2*ONE, 0));
    send_word(pack_item(0, 0, 0, ONE, ONE, 0, 0, -ONE));
    send_word(pack_item(-ONE, 0, 0, ONE, ONE, 0, 0, -ONE));
    send_word(pack_item(5*ONE, 0, 0, ONE, ONE, 0, 0, -ONE));
    send_word(pack_item(0, 0, 0, 0, 1, 1, 2, 3));
    send_word(pack_item(0, 0, MAXC, 0, MINC, 1, MAXC, 2));
    send_word(pack_item(0, 0, 0, 0, 1, MAXC, 0, MINC));
    send_word(pack_item(7*ONE, -2*ONE, -3*ONE, 2*ONE, 4*ONE, 5*ONE, ONE, -6*ONE));
  endtask

  initial begin
    logic [ccpt_pkg::TOL_W-1:0] settings[6];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    calm = 0;
    settings = '{31'd0, 31'h7FFF_FFFF, 31'd1, 31'd65536, 31'd0, ccpt_pkg::TOL_RESET};
    settings[4] = $urandom_range(2, 400000);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int phase = 0; phase < 7; phase++) begin
      if (phase > 0) write_tolerance(settings[phase-1]);
      calm = (phase == 3);
      if (phase < 2) send_directed();
      for (int i = 0; i < 220; i++) send_word(random_item());
      drain_results();
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall = 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_word(m_tdata);
      if (stall > 0) begin
        stall--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = pick_gap();
      end
      m_tready <= (stall == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### sim.f
rtl/ccpt_pkg.sv
rtl/ccpt_div.sv
rtl/circumcircle_point_test.sv
bench/circumcircle_point_test_tb.sv
